@@ rtl/rar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Types and constants for the rational arithmetic reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int OPERAND_W = 16;
  localparam int PROD_W    = 2 * OPERAND_W;
  localparam int RAW_W     = 2 * OPERAND_W + 1;
  localparam int MAG_W     = 2 * OPERAND_W;
  localparam int RES_W     = 32;
  localparam int CNT_W     = $clog2(MAG_W);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                         op;
    logic signed [OPERAND_W-1:0] a_num;
    logic signed [OPERAND_W-1:0] a_den;
    logic signed [OPERAND_W-1:0] b_num;
    logic signed [OPERAND_W-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                    undefined;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_FORM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_fire;
    logic gcd_done;
    logic both_zero;
    logic cnt_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic in_ready;
    logic form;
    logic gcd;
    logic divn;
    logic divd;
    logic finish;
  } ctrl_t;

endpackage

@@ rtl/rational_arithmetic_reduce_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce_top
// Fraction add/sub/mul/div with reduction to lowest terms.
// ----------------------------------------------------------------------------
// One word at a time. The single signed multiplier forms three products in
// turn (ST_MUL1 to ST_MUL3), ST_FORM forms the raw parts, then a binary gcd
// runs on the shared subtractor (one shift or subtract/swap per cycle), then
// two bit-serial divisions run on the same subtractor, and ST_DONE loads the
// output register once the output is free.
// Both raw parts zero gives 0/0 with undefined set.
module rational_arithmetic_reduce_top
  import rar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  state_t  state;
  ctrl_t   ctrl;
  status_t sts;

  in_word_t              in_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p3_r;
  logic [MAG_W-1:0]      x_r, y_r, nm_r, dm_r, rem_r, dv_r, qn_r, qd_r;
  logic                  sn_r, sd_r, undef_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;
  out_word_t             out_r;

  logic signed [OPERAND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]    mul_res;
  logic signed [RAW_W-1:0]     p1e, p2e, p3e, rn, rd;
  logic [MAG_W:0]              sub_a, sub_b, sub_d, trial;
  logic                        sub_borrow, qbit;
  logic [MAG_W-1:0]            rem_nxt, dv_nxt;
  logic                        x_zero, y_zero;

  function automatic logic [RES_W-1:0] to_res(input logic [MAG_W-1:0] mag,
                                              input logic neg);
    logic [63:0] e;
    e = {{(64-MAG_W){1'b0}}, mag};
    if (neg) e = -e;
    return e[RES_W-1:0];
  endfunction

  rar_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .state (state),
    .ctrl  (ctrl)
  );

  assign x_zero = (x_r == '0);
  assign y_zero = (y_r == '0);

  assign sts.in_fire   = in_valid && ctrl.in_ready;
  assign sts.gcd_done  = x_zero || y_zero;
  assign sts.both_zero = x_zero && y_zero;
  assign sts.cnt_last  = (cnt_r == CNT_W'(MAG_W - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // single multiplier, one product per cycle
  always_comb begin
    mul_a = in_r.a_den;
    mul_b = in_r.b_den;
    case (state)
      ST_MUL1: begin
        mul_a = in_r.a_num;
        mul_b = (in_r.op == OP_MUL) ? in_r.b_num : in_r.b_den;
      end
      ST_MUL2: begin
        mul_a = in_r.a_den;
        mul_b = in_r.b_num;
      end
      default: begin
        mul_a = in_r.a_den;
        mul_b = in_r.b_den;
      end
    endcase
  end

  assign mul_res = PROD_W'(mul_a * mul_b);

  always_comb begin
    p1e = RAW_W'(p1_r);
    p2e = RAW_W'(p2_r);
    p3e = RAW_W'(p3_r);
    rn  = p1e;
    rd  = p3e;
    case (in_r.op)
      OP_ADD: rn = p1e + p2e;
      OP_SUB: rn = p1e - p2e;
      OP_MUL: rn = p1e;
      OP_DIV: begin
        rn = p1e;
        rd = p2e;
        if (p2e < 0) begin
          rn = -p1e;
          rd = -p2e;
        end
      end
      default: rn = p1e;
    endcase
  end

  // shared subtractor: x - y in the gcd, trial remainder - g in the divisions
  assign trial = {rem_r, dv_r[MAG_W-1]};
  assign sub_a = ctrl.gcd ? {1'b0, x_r} : trial;
  assign sub_b = ctrl.gcd ? {1'b0, y_r} : {1'b0, x_r};

  rar_sub #(.W(MAG_W + 1)) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_d),
    .borrow (sub_borrow)
  );

  assign qbit    = !sub_borrow;
  assign rem_nxt = qbit ? sub_d[MAG_W-1:0] : trial[MAG_W-1:0];
  assign dv_nxt  = {dv_r[MAG_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (sts.in_fire) begin
      in_r    <= in_data;
      undef_r <= 1'b0;
    end
    case (state)
      ST_MUL1: p1_r <= mul_res;
      ST_MUL2: p2_r <= mul_res;
      ST_MUL3: p3_r <= mul_res;
      default: ;
    endcase
    if (ctrl.form) begin
      sn_r <= rn[RAW_W-1];
      sd_r <= rd[RAW_W-1];
      x_r  <= rn[RAW_W-1] ? MAG_W'(-rn) : MAG_W'(rn);
      nm_r <= rn[RAW_W-1] ? MAG_W'(-rn) : MAG_W'(rn);
      y_r  <= rd[RAW_W-1] ? MAG_W'(-rd) : MAG_W'(rd);
      dm_r <= rd[RAW_W-1] ? MAG_W'(-rd) : MAG_W'(rd);
    end
    if (ctrl.gcd) begin
      rem_r <= '0;
      dv_r  <= nm_r;
      if (x_zero && y_zero) begin
        undef_r <= 1'b1;
      end else if (x_zero) begin
        x_r <= y_r;
      end else if (y_zero) begin
        x_r <= x_r;
      end else if (!x_r[0] && !y_r[0]) begin
        // common factor of two: strip it from the parts being reduced too
        x_r  <= x_r >> 1;
        y_r  <= y_r >> 1;
        nm_r <= nm_r >> 1;
        dm_r <= dm_r >> 1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (!sub_borrow) begin
        x_r <= sub_d[MAG_W-1:0];
      end else begin
        x_r <= y_r;
        y_r <= x_r;
      end
    end
    if (ctrl.divn || ctrl.divd) begin
      if (sts.cnt_last) begin
        rem_r <= '0;
        dv_r  <= dm_r;
        if (ctrl.divn) qn_r <= dv_nxt;
        else           qd_r <= dv_nxt;
      end else begin
        rem_r <= rem_nxt;
        dv_r  <= dv_nxt;
      end
    end
    if (ctrl.finish) begin
      out_r.undefined <= undef_r;
      out_r.res_num   <= undef_r ? '0 : to_res(qn_r, sn_r);
      out_r.res_den   <= undef_r ? '0 : to_res(qd_r, sd_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((ctrl.divn || ctrl.divd) && !sts.cnt_last) cnt_r <= cnt_r + 1'b1;
      else                                          cnt_r <= '0;
      if (ctrl.finish)     out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = !ctrl.in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.undefined) |-> (out_data.res_num == 0 && out_data.res_den == 0))
    else $error("undefined result not forced to 0/0");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_DIVN || state == ST_DIVD) |-> (x_r != '0))
    else $error("division by zero gcd");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |-> (!out_valid_r || !out_stall))
    else $error("output overwritten while stalled");

endmodule

@@ rtl/rar_sub.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_sub
// Shared subtractor with borrow, used for gcd steps and division steps.
// ----------------------------------------------------------------------------
module rar_sub #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

@@ rtl/rar_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_fsm
// Sequencer: multiply, form raw parts, binary gcd, two serial divisions.
// ----------------------------------------------------------------------------
module rar_fsm
  import rar_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t sts,
  output state_t  state,
  output ctrl_t   ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (sts.in_fire) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_FORM;
      ST_FORM: state_nxt = ST_GCD;
      ST_GCD: begin
        if (sts.gcd_done) state_nxt = sts.both_zero ? ST_DONE : ST_DIVN;
      end
      ST_DIVN: if (sts.cnt_last) state_nxt = ST_DIVD;
      ST_DIVD: if (sts.cnt_last) state_nxt = ST_DONE;
      ST_DONE: if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.in_ready = (state_r == ST_IDLE);
    ctrl.form     = (state_r == ST_FORM);
    ctrl.gcd      = (state_r == ST_GCD);
    ctrl.divn     = (state_r == ST_DIVN);
    ctrl.divd     = (state_r == ST_DIVD);
    ctrl.finish   = (state_r == ST_DONE) && sts.out_free;
  end

  assign state = state_r;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic reduce block.
// ----------------------------------------------------------------------------
// A directed table covers operand extremes, every op, the 0/0 case, zero
// denominators, most negative operands and the divide sign flip. Random words
// follow. Every result is checked field by field against a local model of the
// cross-multiply, gcd and reduce steps. Both sides idle at random.
module tb_top
  import rar_pkg::*;
();

  localparam int N_RANDOM = 1300;
  localparam int WDOG_MAX = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  out_word_t fraction_q[$];
  int        n_errors;
  int        idle_cycles;
  bit        calm;
  bit        sending_done;

  rational_arithmetic_reduce_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic out_word_t reduce_fraction(in_word_t w);
    longint an, ad, bn, bd, rn, rd, g;
    longint unsigned x, y, r;
    out_word_t res;
    an = w.a_num;
    ad = w.a_den;
    bn = w.b_num;
    bd = w.b_den;
    case (w.op)
      OP_ADD: begin
        rn = an * bd + ad * bn;
        rd = ad * bd;
      end
      OP_SUB: begin
        rn = an * bd - ad * bn;
        rd = ad * bd;
      end
      OP_MUL: begin
        rn = an * bn;
        rd = ad * bd;
      end
      default: begin
        rn = an * bd;
        rd = ad * bn;
        if (rd < 0) begin
          rn = -rn;
          rd = -rd;
        end
      end
    endcase
    x = abs_of(rn);
    y = abs_of(rd);
    if (y > x) begin
      r = x;
      x = y;
      y = r;
    end
    while (y > 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    res = '0;
    if (x == 0) begin
      res.undefined = 1'b1;
    end else begin
      g = longint'(x);
      res.res_num = 32'(rn / g);
      res.res_den = 32'(rd / g);
    end
    return res;
  endfunction

  // directed rows; known marks a hand-typed expectation
  typedef struct {
    op_t       op;
    int        an, ad, bn, bd;
    bit        known;
    out_word_t res;
  } row_t;

  row_t rows[$];

  function automatic out_word_t frac(int n, int d, bit u);
    out_word_t f;
    f.res_num = n;
    f.res_den = d;
    f.undefined = u;
    return f;
  endfunction

  function automatic row_t mk(op_t op, int an, int ad, int bn, int bd,
                              bit known = 0, out_word_t res = '0);
    row_t rw;
    rw.op = op; rw.an = an; rw.ad = ad; rw.bn = bn; rw.bd = bd;
    rw.known = known; rw.res = res;
    return rw;
  endfunction

  initial begin
    rows.push_back(mk(OP_ADD, 1, 2, 1, 2, 1, frac(1, 1, 0)));
    rows.push_back(mk(OP_SUB, 1, 2, 1, 2, 1, frac(0, 1, 0)));
    rows.push_back(mk(OP_MUL, 0, 5, 0, 7, 1, frac(0, 1, 0)));
    rows.push_back(mk(OP_MUL, 0, 0, 0, 0, 1, frac(0, 0, 1)));
    rows.push_back(mk(OP_ADD, 0, 0, 3, 0, 1, frac(0, 0, 1)));
    rows.push_back(mk(OP_DIV, 3, 4, 0, 5, 1, frac(1, 0, 0)));
    rows.push_back(mk(OP_DIV, -3, 4, 0, 5, 1, frac(-1, 0, 0)));
    rows.push_back(mk(OP_MUL, 5, 0, 2, 3, 1, frac(1, 0, 0)));
    rows.push_back(mk(OP_DIV, 1, 2, -1, 3, 1, frac(-3, 2, 0)));
    rows.push_back(mk(OP_ADD, 1, -2, 1, 3, 1, frac(1, -6, 0)));
    rows.push_back(mk(OP_MUL, 32767, 1, 32767, 1));
    rows.push_back(mk(OP_MUL, -32767, 32767, 32767, -32767));
    rows.push_back(mk(OP_ADD, 32767, 32766, -32767, 32765));
    rows.push_back(mk(OP_SUB, -32767, 32767, 32767, -1));
    rows.push_back(mk(OP_DIV, 32767, -32767, -32767, 32767));
    rows.push_back(mk(OP_MUL, -32768, 1, -32768, 1));
    rows.push_back(mk(OP_DIV, -32768, 1, 1, -32768));
    rows.push_back(mk(OP_ADD, -32768, -32768, -32768, -32768));
    rows.push_back(mk(OP_SUB, -32768, 3, 32767, -32768));
    rows.push_back(mk(OP_DIV, 6, 0, 4, 0));
    rows.push_back(mk(OP_DIV, 0, 7, 0, 9));
    rows.push_back(mk(OP_SUB, 12, 18, 8, 12));
    rows.push_back(mk(OP_MUL, -1, -1, -1, -1));
  end

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8001);
      1:       return 16'(int'($urandom_range(0, 6)) - 3);
      2:       return 16'h8000;
      3, 4:    return 16'($urandom_range(0, 255) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'($urandom);
    endcase
  endfunction

  // idle decision: ~38% unless in the calm stretch
  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 38);
  endfunction

  // valid stays up between back-to-back words; drops only for a gap
  task automatic send_word(in_word_t w);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    in_word_t w;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    calm = 1'b0;
    sending_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) begin
      w.op = rows[i].op;
      w.a_num = 16'(rows[i].an);
      w.a_den = 16'(rows[i].ad);
      w.b_num = 16'(rows[i].bn);
      w.b_den = 16'(rows[i].bd);
      if (rows[i].known) begin
        if (reduce_fraction(w) != rows[i].res) $error("table row %0d inconsistent", i);
        fraction_q.push_back(rows[i].res);
      end else begin
        fraction_q.push_back(reduce_fraction(w));
      end
      send_word(w);
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      calm = (k >= 400 && k < 600);
      w.op = op_t'($urandom_range(0, 3));
      w.a_num = rand_operand();
      w.a_den = rand_operand();
      w.b_num = rand_operand();
      w.b_den = rand_operand();
      fraction_q.push_back(reduce_fraction(w));
      send_word(w);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // result side stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= take_gap();
    end
  end

  // checker and watchdog
  initial begin
    out_word_t exp_w;
    n_errors = 0;
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      idle_cycles++;
      if (in_valid && !in_stall) idle_cycles = 0;
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (fraction_q.size() == 0) begin
          $error("unexpected result word");
          n_errors++;
        end else begin
          exp_w = fraction_q.pop_front();
          if (out_data.res_num !== exp_w.res_num) begin
            $error("res_num expected %0d actual %0d", exp_w.res_num, out_data.res_num);
            n_errors++;
          end
          if (out_data.res_den !== exp_w.res_den) begin
            $error("res_den expected %0d actual %0d", exp_w.res_den, out_data.res_den);
            n_errors++;
          end
          if (out_data.undefined !== exp_w.undefined) begin
            $error("undefined expected %0b actual %0b", exp_w.undefined,
                   out_data.undefined);
            n_errors++;
          end
        end
      end
      if (sending_done && fraction_q.size() == 0) begin
        repeat (200) begin
          @(posedge clk);
          if (out_valid && !out_stall) begin
            $error("unexpected result word");
            n_errors++;
          end
        end
        if (n_errors == 0) $display("rational_arithmetic_reduce_top: match");
        else $display("rational_arithmetic_reduce_top: mismatch");
        $finish;
      end
      if (idle_cycles >= WDOG_MAX) begin
        $error("timeout with %0d words outstanding", fraction_q.size());
        $display("rational_arithmetic_reduce_top: mismatch");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
rtl/rar_pkg.sv
rtl/rar_sub.sv
rtl/rar_fsm.sv
rtl/rational_arithmetic_reduce_top.sv
bench/tb_top.sv
